[hw/rtl/page_sharer_comm_detector_defines.svh]
// Assertion macros used by the detector back end (psc_back).
`ifndef PAGE_SHARER_COMM_DETECTOR_DEFINES_SVH
`define PAGE_SHARER_COMM_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PSC_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
`define PSC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define PSC_ASSERT_NOW(lbl, cond, prop, msg)
`define PSC_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

[hw/rtl/psc_pkg.sv]
`default_nettype none
package psc_pkg;

  localparam int ADDR_W    = 48;
  localparam int TID_W     = 5;
  localparam int OP_W      = 2;
  localparam int VALUE_W   = 32;

  localparam int HASH_BITS_DEF  = 10;
  localparam int PAGE_BITS_DEF  = 12;
  localparam int THREADS_DEF    = 32;
  localparam int COUNT_BITS_DEF = 32;

  localparam logic [31:0] HASH_MULT = 32'h61C88647;

  typedef enum logic [OP_W-1:0] {
    OP_ACCESS      = 2'd0,
    OP_RD_SHARE    = 2'd1,
    OP_RD_CONFLICT = 2'd2,
    OP_NOP         = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_TBL,
    S_RDC,
    S_C1,
    S_C2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic               tag_conflict;
    logic [1:0]         pairs_counted;
    logic [TID_W-1:0]   first_peer;
    logic [TID_W-1:0]   second_peer;
    logic [VALUE_W-1:0] counter_value;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/psc_ram.sv]
`default_nettype none
module psc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/psc_front.sv]
`default_nettype none
module psc_front #(
  parameter int HASH_BITS = psc_pkg::HASH_BITS_DEF,
  parameter int PAGE_BITS = psc_pkg::PAGE_BITS_DEF,
  parameter int QW = 2 + 5 + 48 + 5 + HASH_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        enable,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [psc_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [psc_pkg::TID_W-1:0]   in_thread_id,
  input  wire logic [psc_pkg::ADDR_W-1:0]  in_access_address,
  input  wire logic [psc_pkg::TID_W-1:0]   in_peer_id,
  input  wire logic                        q_ready,
  output logic                             q_push,
  output logic [QW-1:0]                    q_data
);
  import psc_pkg::*;

  logic                 v_r, v_nxt;
  logic [OP_W-1:0]      op_r;
  logic [TID_W-1:0]     tid_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [TID_W-1:0]     peer_r;
  logic [HASH_BITS-1:0] hash_r;
  logic [31:0]          page32;
  logic [31:0]          prod;
  logic                 accept;

  assign page32   = 32'(in_access_address >> PAGE_BITS);
  assign prod     = page32 * HASH_MULT;
  assign q_push   = v_r && q_ready;
  assign in_ready = enable && (!v_r || q_ready);
  assign accept   = in_valid && in_ready;
  assign q_data   = {op_r, tid_r, addr_r, peer_r, hash_r};

  always_comb begin
    v_nxt = v_r;
    if (q_push) begin
      v_nxt = 1'b0;
    end
    if (accept) begin
      v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    if (accept) begin
      op_r   <= in_opcode;
      tid_r  <= in_thread_id;
      addr_r <= in_access_address;
      peer_r <= in_peer_id;
      hash_r <= prod[31 -: HASH_BITS];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/psc_fifo.sv]
`default_nettype none
module psc_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              not_full,
  input  wire logic         pop,
  output logic              not_empty,
  output logic [W-1:0]      rdata
);
  logic [W-1:0] ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign not_full  = cnt_r != 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign rdata     = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/psc_back.sv]
`default_nettype none
`include "page_sharer_comm_detector_defines.svh"
module psc_back #(
  parameter int HASH_BITS  = psc_pkg::HASH_BITS_DEF,
  parameter int PAGE_BITS  = psc_pkg::PAGE_BITS_DEF,
  parameter int THREADS    = psc_pkg::THREADS_DEF,
  parameter int COUNT_BITS = psc_pkg::COUNT_BITS_DEF,
  parameter int QW = 2 + 5 + 48 + 5 + HASH_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire logic [QW-1:0] q_data,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  wire logic          out_ready,
  output psc_pkg::res_t      out_res
);
  import psc_pkg::*;

  localparam int TAG_W     = ADDR_W - PAGE_BITS;
  localparam int TBL_DEPTH = 1 << HASH_BITS;
  localparam int ENT_W     = TAG_W + 2 * (TID_W + 1);
  localparam int CNT_DEPTH = THREADS * THREADS;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);
  localparam int CLR_N     = (TBL_DEPTH > CNT_DEPTH) ? TBL_DEPTH : CNT_DEPTH;
  localparam int CLR_W     = $clog2(CLR_N + 1);

  function automatic logic [CNT_AW-1:0] cidx(logic [TID_W-1:0] r, logic [TID_W-1:0] c);
    cidx = CNT_AW'(int'(r) * THREADS + int'(c));
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] x);
    sat_inc = (x == '1) ? x : x + COUNT_BITS'(1);
  endfunction

  logic [OP_W-1:0]      h_op;
  logic [TID_W-1:0]     h_tid, h_peer;
  logic [ADDR_W-1:0]    h_addr;
  logic [HASH_BITS-1:0] h_hash;

  assign {h_op, h_tid, h_addr, h_peer, h_hash} = q_data;

  state_t               state_r, state_nxt;
  logic [TID_W-1:0]     tid_r, tid_nxt;
  logic [TAG_W-1:0]     page_r, page_nxt;
  logic [HASH_BITS-1:0] hash_r, hash_nxt;
  logic [31:0]          conf_r, conf_nxt;
  res_t                 res_r, res_nxt;
  logic [CNT_AW-1:0]    a1_r, a1_nxt, a2_r, a2_nxt;
  logic [COUNT_BITS-1:0] wval_r, wval_nxt;
  logic [CLR_W-1:0]     clr_r, clr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  res_t                 out_res_r, out_res_nxt;

  logic                  tbl_we;
  logic [HASH_BITS-1:0]  tbl_waddr;
  logic [ENT_W-1:0]      tbl_wdata, tbl_rdata;
  logic                  cnt_we;
  logic [CNT_AW-1:0]     cnt_waddr, cnt_raddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

  logic [TAG_W-1:0]      e_tag;
  logic                  e_v0, e_v1;
  logic [TID_W-1:0]      e_id0, e_id1;
  logic [TAG_W-1:0]      n_tag;
  logic                  n_v0, n_v1;
  logic [TID_W-1:0]      n_id0, n_id1;
  logic [COUNT_BITS-1:0] inc, base;
  logic [63:0]           wide;

  assign {e_tag, e_v0, e_id0, e_v1, e_id1} = tbl_rdata;

  psc_ram #(.WIDTH(ENT_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(h_hash), .rdata(tbl_rdata)
  );

  psc_ram #(.WIDTH(COUNT_BITS), .DEPTH(CNT_DEPTH)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  assign clearing  = state_r == S_CLR;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign wide      = 64'(cnt_rdata);
  assign base      = (a2_r == a1_r) ? wval_r : cnt_rdata;

  always_comb begin
    state_nxt     = state_r;
    tid_nxt       = tid_r;
    page_nxt      = page_r;
    hash_nxt      = hash_r;
    conf_nxt      = conf_r;
    res_nxt       = res_r;
    a1_nxt        = a1_r;
    a2_nxt        = a2_r;
    wval_nxt      = wval_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;
    tbl_we        = 1'b0;
    tbl_waddr     = hash_r;
    tbl_wdata     = '0;
    cnt_we        = 1'b0;
    cnt_waddr     = a1_r;
    cnt_wdata     = '0;
    cnt_raddr     = cidx(h_tid, h_peer);
    n_tag = e_tag; n_v0 = e_v0; n_id0 = e_id0; n_v1 = e_v1; n_id1 = e_id1;
    inc   = sat_inc(cnt_rdata);
    case (state_r)
      S_CLR: begin
        tbl_we    = int'(clr_r) < TBL_DEPTH;
        tbl_waddr = clr_r[HASH_BITS-1:0];
        cnt_we    = int'(clr_r) < CNT_DEPTH;
        cnt_waddr = clr_r[CNT_AW-1:0];
        clr_nxt   = clr_r + CLR_W'(1);
        if (int'(clr_r) == CLR_N - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          tid_nxt  = h_tid;
          page_nxt = TAG_W'(h_addr >> PAGE_BITS);
          hash_nxt = h_hash;
          res_nxt  = '0;
          state_nxt = S_OUT;
          case (op_t'(h_op))
            OP_ACCESS: begin
              if (int'(h_tid) < THREADS) begin
                state_nxt = S_TBL;
              end
            end
            OP_RD_SHARE: begin
              if (int'(h_tid) < THREADS && int'(h_peer) < THREADS) begin
                state_nxt = S_RDC;
              end
            end
            OP_RD_CONFLICT: begin
              res_nxt.counter_value = conf_r;
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end
      S_TBL: begin
        if (e_tag != page_r) begin
          if (e_tag != '0) begin
            res_nxt.tag_conflict = 1'b1;
            conf_nxt = (conf_r == '1) ? conf_r : conf_r + 32'd1;
          end
          n_tag = page_r; n_v0 = 1'b1; n_id0 = tid_r; n_v1 = 1'b0; n_id1 = '0;
        end else if (!e_v0 && !e_v1) begin
          n_v0 = 1'b1; n_id0 = tid_r;
        end else if (e_v0 && e_v1) begin
          if (e_id0 != tid_r && e_id1 != tid_r) begin
            res_nxt.pairs_counted = 2'd2;
            res_nxt.first_peer    = e_id0;
            res_nxt.second_peer   = e_id1;
            n_id1 = e_id0; n_id0 = tid_r;
          end else if (e_id0 == tid_r) begin
            res_nxt.pairs_counted = 2'd1;
            res_nxt.first_peer    = e_id1;
          end else begin
            res_nxt.pairs_counted = 2'd1;
            res_nxt.first_peer    = e_id0;
          end
        end else if (!e_v0) begin
          if (e_id1 != tid_r) begin
            n_v0 = 1'b1; n_id0 = tid_r;
            res_nxt.pairs_counted = 2'd1;
            res_nxt.first_peer    = e_id1;
          end
        end else begin
          if (e_id0 != tid_r) begin
            n_v1 = 1'b1; n_id1 = tid_r;
            res_nxt.pairs_counted = 2'd1;
            res_nxt.first_peer    = e_id0;
          end
        end
        tbl_we    = 1'b1;
        tbl_wdata = {n_tag, n_v0, n_id0, n_v1, n_id1};
        a1_nxt    = cidx(tid_r, res_nxt.first_peer);
        a2_nxt    = cidx(tid_r, res_nxt.second_peer);
        cnt_raddr = a1_nxt;
        state_nxt = (res_nxt.pairs_counted != 2'd0) ? S_C1 : S_OUT;
      end
      S_RDC: begin
        res_nxt.counter_value = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
        state_nxt = S_OUT;
      end
      S_C1: begin
        cnt_we    = 1'b1;
        cnt_waddr = a1_r;
        cnt_wdata = inc;
        wval_nxt  = inc;
        cnt_raddr = a2_r;
        state_nxt = (res_r.pairs_counted == 2'd2) ? S_C2 : S_OUT;
      end
      S_C2: begin
        cnt_we    = 1'b1;
        cnt_waddr = a2_r;
        cnt_wdata = sat_inc(base);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      conf_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      conf_r      <= conf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tid_r     <= tid_nxt;
    page_r    <= page_nxt;
    hash_r    <= hash_nxt;
    res_r     <= res_nxt;
    a1_r      <= a1_nxt;
    a2_r      <= a2_nxt;
    wval_r    <= wval_nxt;
    out_res_r <= out_res_nxt;
  end

  `PSC_ASSERT_NOW(a_no_pop_clr, state_r == S_CLR, !q_pop, "pop during clearing pass")
  `PSC_ASSERT_NEXT(a_conf_mono, rst_n, conf_r >= $past(conf_r), "conflict count decreased")
  `PSC_ASSERT_NEXT(a_second_bump, state_r == S_C1 && res_r.pairs_counted == 2'd2, state_r == S_C2, "second increment skipped")
  `PSC_ASSERT_NOW(a_out_hold, out_valid_r && !out_ready && state_r == S_OUT, !out_valid_nxt || out_res_nxt == out_res_r, "pending result overwritten")
endmodule
`default_nettype wire

[hw/rtl/page_sharer_comm_detector.sv]
// Per item, the back-end sequencer runs from S_IDLE to S_OUT: conflict reads, no-ops and
// out-of-range items go straight there, counter reads pass S_RDC, and accesses pass S_TBL
// and then S_C1 (and S_C2 for a second counter increment) when pairs are counted. It takes
// one item at a time; the front register and a two-entry FIFO take new inputs until full.
// Reset: synchronous active-low; afterwards a clearing pass over max(2^HASH_BITS,
// THREADS*THREADS) addresses zeroes both memories while in_ready is held low.
`default_nettype none
module page_sharer_comm_detector #(
  parameter int HASH_BITS  = psc_pkg::HASH_BITS_DEF,
  parameter int PAGE_BITS  = psc_pkg::PAGE_BITS_DEF,
  parameter int THREADS    = psc_pkg::THREADS_DEF,
  parameter int COUNT_BITS = psc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [psc_pkg::OP_W-1:0]     in_opcode,
  input  wire logic [psc_pkg::TID_W-1:0]    in_thread_id,
  input  wire logic [psc_pkg::ADDR_W-1:0]   in_access_address,
  input  wire logic [psc_pkg::TID_W-1:0]    in_peer_id,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_tag_conflict,
  output logic [1:0]                        out_pairs_counted,
  output logic [psc_pkg::TID_W-1:0]         out_first_peer,
  output logic [psc_pkg::TID_W-1:0]         out_second_peer,
  output logic [psc_pkg::VALUE_W-1:0]       out_counter_value
);
  import psc_pkg::*;

  localparam int QW = OP_W + TID_W + ADDR_W + TID_W + HASH_BITS;

  logic          q_push, q_pop, q_not_full, q_not_empty, clearing;
  logic [QW-1:0] f_data, q_data;
  res_t          res;

  psc_front #(.HASH_BITS(HASH_BITS), .PAGE_BITS(PAGE_BITS), .QW(QW)) u_front (
    .clk(clk), .rst_n(rst_n), .enable(!clearing),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_thread_id(in_thread_id),
    .in_access_address(in_access_address), .in_peer_id(in_peer_id),
    .q_ready(q_not_full), .q_push(q_push), .q_data(f_data)
  );

  psc_fifo #(.W(QW)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(f_data), .not_full(q_not_full),
    .pop(q_pop), .not_empty(q_not_empty), .rdata(q_data)
  );

  psc_back #(
    .HASH_BITS(HASH_BITS), .PAGE_BITS(PAGE_BITS), .THREADS(THREADS),
    .COUNT_BITS(COUNT_BITS), .QW(QW)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_not_empty), .q_data(q_data), .q_pop(q_pop),
    .clearing(clearing), .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign out_tag_conflict  = res.tag_conflict;
  assign out_pairs_counted = res.pairs_counted;
  assign out_first_peer    = res.first_peer;
  assign out_second_peer   = res.second_peer;
  assign out_counter_value = res.counter_value;
endmodule
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import psc_pkg::*;

  localparam int TBL_SIZE = 1 << HASH_BITS_DEF;
  localparam int NTHR = THREADS_DEF;
  localparam int PAGE_W = ADDR_W - PAGE_BITS_DEF;
  localparam int RANDOM_ITEMS = 480;

  typedef struct {
    op_t               op;
    logic [TID_W-1:0]  tid;
    logic [ADDR_W-1:0] addr;
    logic [TID_W-1:0]  peer;
    bit                known;
    res_t              res;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] in_opcode;
  logic [TID_W-1:0] in_thread_id;
  logic [ADDR_W-1:0] in_access_address;
  logic [TID_W-1:0] in_peer_id;
  logic out_valid;
  logic out_ready;
  logic out_tag_conflict;
  logic [1:0] out_pairs_counted;
  logic [TID_W-1:0] out_first_peer;
  logic [TID_W-1:0] out_second_peer;
  logic [VALUE_W-1:0] out_counter_value;

  page_sharer_comm_detector u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_thread_id(in_thread_id),
    .in_access_address(in_access_address), .in_peer_id(in_peer_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tag_conflict(out_tag_conflict), .out_pairs_counted(out_pairs_counted),
    .out_first_peer(out_first_peer), .out_second_peer(out_second_peer),
    .out_counter_value(out_counter_value)
  );

  logic [PAGE_W-1:0] tag_mem [TBL_SIZE];
  bit                slot0_vld [TBL_SIZE];
  bit                slot1_vld [TBL_SIZE];
  logic [TID_W-1:0]  slot0_tid [TBL_SIZE];
  logic [TID_W-1:0]  slot1_tid [TBL_SIZE];
  logic [31:0]       share_mtx [NTHR][NTHR];
  logic [31:0]       evictions;

  res_t expected_results[$];
  dir_row_t dir_rows[$];
  int errors;
  int results_seen;
  int hold_cnt;
  bit quiet;
  bit long_hold_done;
  logic [PAGE_W-1:0] page_pool[8];

  function automatic logic [HASH_BITS_DEF-1:0] page_index(logic [PAGE_W-1:0] page);
    logic [31:0] prod;
    prod = page[31:0] * HASH_MULT;
    return prod[31 -: HASH_BITS_DEF];
  endfunction

  function automatic void bump_share(int row, int col);
    if (share_mtx[row][col] != '1) share_mtx[row][col]++;
  endfunction

  function automatic res_t sharing_outcome(op_t op, logic [TID_W-1:0] t,
                                           logic [ADDR_W-1:0] addr,
                                           logic [TID_W-1:0] peer);
    res_t r;
    logic [PAGE_W-1:0] page;
    logic [HASH_BITS_DEF-1:0] h;
    r = '0;
    if (op == OP_RD_SHARE) begin
      if (t < NTHR && peer < NTHR) r.counter_value = share_mtx[t][peer];
    end else if (op == OP_RD_CONFLICT) begin
      r.counter_value = evictions;
    end else if (op == OP_ACCESS && t < NTHR) begin
      page = addr[ADDR_W-1:PAGE_BITS_DEF];
      h = page_index(page);
      if (tag_mem[h] != page) begin
        if (tag_mem[h] != '0) begin
          r.tag_conflict = 1'b1;
          if (evictions != '1) evictions++;
        end
        tag_mem[h] = page;
        slot0_vld[h] = 1; slot0_tid[h] = t;
        slot1_vld[h] = 0; slot1_tid[h] = '0;
      end else if (!slot0_vld[h] && !slot1_vld[h]) begin
        slot0_vld[h] = 1; slot0_tid[h] = t;
      end else if (slot0_vld[h] && slot1_vld[h]) begin
        if (slot0_tid[h] != t && slot1_tid[h] != t) begin
          bump_share(t, slot0_tid[h]);
          bump_share(t, slot1_tid[h]);
          r.pairs_counted = 2'd2;
          r.first_peer = slot0_tid[h];
          r.second_peer = slot1_tid[h];
          slot1_tid[h] = slot0_tid[h];
          slot0_tid[h] = t;
        end else if (slot0_tid[h] == t) begin
          bump_share(t, slot1_tid[h]);
          r.pairs_counted = 2'd1; r.first_peer = slot1_tid[h];
        end else begin
          bump_share(t, slot0_tid[h]);
          r.pairs_counted = 2'd1; r.first_peer = slot0_tid[h];
        end
      end else if (!slot0_vld[h]) begin
        if (slot1_tid[h] != t) begin
          slot0_vld[h] = 1; slot0_tid[h] = t;
          bump_share(t, slot1_tid[h]);
          r.pairs_counted = 2'd1; r.first_peer = slot1_tid[h];
        end
      end else if (slot0_tid[h] != t) begin
        slot1_vld[h] = 1; slot1_tid[h] = t;
        bump_share(t, slot0_tid[h]);
        r.pairs_counted = 2'd1; r.first_peer = slot0_tid[h];
      end
    end
    return r;
  endfunction

  function automatic res_t mk_res(bit c, int pairs, int p1, int p2, logic [31:0] v);
    res_t r;
    r.tag_conflict = c;
    r.pairs_counted = pairs[1:0];
    r.first_peer = p1[TID_W-1:0];
    r.second_peer = p2[TID_W-1:0];
    r.counter_value = v;
    return r;
  endfunction

  function automatic void add_row(op_t op, int t, logic [ADDR_W-1:0] addr, int peer,
                                  bit known, res_t r);
    dir_row_t row;
    row.op = op; row.tid = t[TID_W-1:0]; row.addr = addr;
    row.peer = peer[TID_W-1:0]; row.known = known; row.res = r;
    dir_rows.push_back(row);
  endfunction

  task automatic send_transaction(op_t op, logic [TID_W-1:0] t, logic [ADDR_W-1:0] addr,
                                  logic [TID_W-1:0] peer, bit known, res_t typed);
    res_t r;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_thread_id <= t;
    in_access_address <= addr;
    in_peer_id <= peer;
    do @(posedge clk); while (!in_ready);
    r = sharing_outcome(op, t, addr, peer);
    expected_results.push_back(known ? typed : r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("page_sharer_comm_detector test failed");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    hold_cnt = 0;
    results_seen = 0;
    long_hold_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%t unexpected result: conflict %0d pairs %0d p1 %0d p2 %0d value %0d",
                   $time, out_tag_conflict, out_pairs_counted, out_first_peer,
                   out_second_peer, out_counter_value);
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (out_tag_conflict !== e.tag_conflict) begin
            errors++;
            $display("%t tag_conflict expected %0d actual %0d", $time, e.tag_conflict,
                     out_tag_conflict);
          end
          if (out_pairs_counted !== e.pairs_counted) begin
            errors++;
            $display("%t pairs_counted expected %0d actual %0d", $time, e.pairs_counted,
                     out_pairs_counted);
          end
          if (out_first_peer !== e.first_peer) begin
            errors++;
            $display("%t first_peer expected %0d actual %0d", $time, e.first_peer,
                     out_first_peer);
          end
          if (out_second_peer !== e.second_peer) begin
            errors++;
            $display("%t second_peer expected %0d actual %0d", $time, e.second_peer,
                     out_second_peer);
          end
          if (out_counter_value !== e.counter_value) begin
            errors++;
            $display("%t counter_value expected %0d actual %0d", $time, e.counter_value,
                     out_counter_value);
          end
        end
        if (results_seen == 80 && !long_hold_done) begin
          long_hold_done = 1;
          hold_cnt = 400;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int sel;
    logic [PAGE_W-1:0] page;
    logic [ADDR_W-1:0] addr;
    errors = 0;
    quiet = 0;
    evictions = '0;
    for (int i = 0; i < TBL_SIZE; i++) begin
      tag_mem[i] = '0;
      slot0_vld[i] = 0; slot1_vld[i] = 0;
      slot0_tid[i] = '0; slot1_tid[i] = '0;
    end
    for (int i = 0; i < NTHR; i++)
      for (int j = 0; j < NTHR; j++) share_mtx[i][j] = '0;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_NOP;
    in_thread_id <= '0;
    in_access_address <= '0;
    in_peer_id <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_row(OP_RD_CONFLICT, 0, 48'h0, 0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(OP_RD_SHARE, 31, 48'h0, 31, 1, mk_res(0, 0, 0, 0, 0));
    add_row(OP_NOP, 31, '1, 31, 1, mk_res(0, 0, 0, 0, 0));
    add_row(OP_ACCESS, 0, 48'h0000_0000_0FFF, 0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(OP_ACCESS, 0, 48'h0000_0000_0010, 0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(OP_ACCESS, 1, 48'h0000_0000_0020, 0, 1, mk_res(0, 1, 0, 0, 0));
    add_row(OP_ACCESS, 2, 48'h0000_0000_0030, 0, 1, mk_res(0, 2, 0, 1, 0));
    add_row(OP_ACCESS, 2, 48'h0000_0000_0040, 0, 1, mk_res(0, 1, 0, 0, 0));
    add_row(OP_ACCESS, 0, 48'h0000_0000_0050, 0, 1, mk_res(0, 1, 2, 0, 0));
    add_row(OP_RD_SHARE, 1, 48'h0, 0, 1, mk_res(0, 0, 0, 0, 1));
    add_row(OP_RD_SHARE, 2, 48'h0, 0, 1, mk_res(0, 0, 0, 0, 2));
    add_row(OP_ACCESS, 3, 48'h1000_0000_0000, 0, 1, mk_res(0, 0, 0, 0, 0));
    add_row(OP_ACCESS, 4, 48'h0000_0000_0000, 0, 1, mk_res(1, 0, 0, 0, 0));
    add_row(OP_RD_CONFLICT, 0, 48'h0, 0, 1, mk_res(0, 0, 0, 0, 1));
    add_row(OP_ACCESS, 31, '1, 0, 0, '0);
    add_row(OP_ACCESS, 31, '1, 0, 0, '0);
    add_row(OP_ACCESS, 30, '1, 0, 0, '0);
    add_row(OP_ACCESS, 29, 48'hFFFF_FFFF_F000, 0, 0, '0);
    add_row(OP_ACCESS, 31, 48'hFFFF_FFFF_F000, 0, 0, '0);
    add_row(OP_ACCESS, 30, 48'h0FFF_FFFF_F123, 0, 0, '0);
    add_row(OP_RD_SHARE, 31, 48'h0, 30, 0, '0);
    add_row(OP_RD_SHARE, 30, '1, 31, 0, '0);
    add_row(OP_RD_CONFLICT, 31, '1, 31, 0, '0);
    foreach (dir_rows[i])
      send_transaction(dir_rows[i].op, dir_rows[i].tid, dir_rows[i].addr,
                       dir_rows[i].peer, dir_rows[i].known, dir_rows[i].res);

    page_pool[0] = '0;
    for (int i = 1; i < 8; i++) page_pool[i] = PAGE_W'({$urandom(), $urandom()});
    page_pool[7] = {~page_pool[6][PAGE_W-1:32], page_pool[6][31:0]};

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n > RANDOM_ITEMS - 60) quiet = 1;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        page = page_pool[$urandom_range(0, 7)];
        addr = {page, 12'($urandom())};
        send_transaction(OP_ACCESS, ($urandom_range(0, 3) == 0) ? 5'($urandom())
                         : 5'($urandom_range(0, 5)), addr, 5'($urandom()), 0, '0);
      end else if (sel < 77) begin
        addr = ADDR_W'({$urandom(), $urandom()});
        send_transaction(OP_ACCESS, 5'($urandom()), addr, 5'($urandom()), 0, '0);
      end else if (sel < 90) begin
        send_transaction(OP_RD_SHARE, 5'($urandom_range(0, 5)),
                         ADDR_W'({$urandom(), $urandom()}),
                         5'($urandom_range(0, 5)), 0, '0);
      end else if (sel < 95) begin
        send_transaction(OP_RD_CONFLICT, 5'($urandom()), ADDR_W'({$urandom(), $urandom()}),
                         5'($urandom()), 0, '0);
      end else begin
        send_transaction(OP_NOP, 5'($urandom()), ADDR_W'({$urandom(), $urandom()}),
                         5'($urandom()), 0, '0);
      end
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("page_sharer_comm_detector test passed");
    end else begin
      $display("page_sharer_comm_detector test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
